// ===== rtl/text_terminal_writer_assert.svh =====
// assertion helpers for the text terminal writer
`ifndef TEXT_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_WRITER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TTW_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TTW_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ttw_pkg.sv =====
package ttw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam int CELL_W    = 16;
    localparam int CHAR_W    = 8;
    localparam int CUR_ROW_W = 5;
    localparam int CUR_COL_W = 7;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE       = 8'h20;
    localparam logic [CHAR_W-1:0] TEXT_COLOR_RESET = 8'h0F;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [CHAR_W-1:0]    char_code;
        logic [CUR_ROW_W-1:0] read_row;
        logic [CUR_COL_W-1:0] read_column;
    } in_item_t;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CUR_COL_W-1:0] cursor_column;
    } out_item_t;

endpackage

// ===== rtl/ttw_ram.sv =====
module ttw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/text_terminal_writer.sv =====
// put-character and read beats: the result is registered in S_DONE once the output register is free
// a line feed that scrolls copies the screen up one row through the single RAM read port,
//   then blanks the bottom row; a clear blanks every cell in the current text color
// one beat is worked on at a time; s_ready drops from acceptance until the result is registered
// reset (aresetn low, synchronous) homes the cursor, sets text_color to 0x0F and then runs a
//   pass writing 0x0F20 to every cell with s_ready low
`include "text_terminal_writer_assert.svh"

module text_terminal_writer
    import ttw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_SCROLL = 7'b0000100,
        S_BLANK  = 7'b0001000,
        S_CLEAR  = 7'b0010000,
        S_DONE   = 7'b0100000,
        S_SPARE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] copy_addr_reg, copy_addr_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [7:0]        color_reg;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    logic              accept;
    logic [ADDR_W-1:0] cursor_addr, read_addr;
    logic              read_in_range;
    logic [COL_W:0]    col_inc;
    logic [31:0]       row_ext, col_ext;

    ttw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_screen (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign cursor_addr = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign read_addr   = ADDR_W'(s_data.read_row) * ADDR_W'(COLUMNS)
                         + ADDR_W'(s_data.read_column);
    assign read_in_range = (32'(s_data.read_row) < ROWS) && (32'(s_data.read_column) < COLUMNS);
    assign col_inc = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign row_ext = 32'(row_reg);
    assign col_ext = 32'(col_reg);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        pend_next      = pend_reg;
        copy_addr_next = copy_addr_reg;
        rd_ok_next     = rd_ok_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[ADDR_W-1:0];
        ram_wdata      = {color_reg, BLANK_CODE};
        ram_re         = 1'b0;
        ram_raddr      = cnt_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_INIT: begin
                // power-on fill uses the reset color, not the live register
                ram_we    = 1'b1;
                ram_wdata = {TEXT_COLOR_RESET, BLANK_CODE};
                if (cnt_reg == CNT_W'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    rd_ok_next = 1'b0;
                    state_next = S_DONE;
                    unique case (s_data.opcode)
                        OP_PUT: begin
                            if (s_data.char_code != NEWLINE_CODE) begin
                                ram_we    = 1'b1;
                                ram_waddr = cursor_addr;
                                ram_wdata = {color_reg, s_data.char_code};
                                col_next  = col_inc[COL_W-1:0];
                            end
                            if (s_data.char_code == NEWLINE_CODE ||
                                col_inc == (COL_W + 1)'(COLUMNS)) begin
                                col_next = '0;
                                if (row_reg == ROW_W'(ROWS - 1)) begin
                                    state_next = S_SCROLL;
                                    cnt_next   = CNT_W'(COLUMNS);
                                    pend_next  = 1'b0;
                                end else begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end
                        end
                        OP_CLEAR: begin
                            row_next   = '0;
                            col_next   = '0;
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_READ: begin
                            ram_re     = 1'b1;
                            ram_raddr  = read_addr;
                            rd_ok_next = read_in_range;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCROLL: begin
                // read one row below, write back the cell read the cycle before
                if (cnt_reg < CNT_W'(CELLS)) begin
                    ram_re = 1'b1;
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = copy_addr_reg;
                    ram_wdata = ram_rdata;
                end
                pend_next      = (cnt_reg < CNT_W'(CELLS));
                copy_addr_next = ADDR_W'(cnt_reg - CNT_W'(COLUMNS));
                if (cnt_reg == CNT_W'(CELLS)) begin
                    state_next = S_BLANK;
                    cnt_next   = CNT_W'((ROWS - 1) * COLUMNS);
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_BLANK, S_CLEAR: begin
                ram_we = 1'b1;
                if (cnt_reg == CNT_W'(CELLS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.cell_value    = rd_ok_reg ? ram_rdata : '0;
                    m_data_next.cursor_row    = row_ext[CUR_ROW_W-1:0];
                    m_data_next.cursor_column = col_ext[CUR_COL_W-1:0];
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cnt_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            pend_reg    <= 1'b0;
            rd_ok_reg   <= 1'b0;
            color_reg   <= TEXT_COLOR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            pend_reg    <= pend_next;
            rd_ok_reg   <= rd_ok_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                color_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= copy_addr_next;
        m_data_reg    <= m_data_next;
    end

    `TTW_ASSERT_NXT(a_one_beat_at_a_time, aclk, aresetn, accept, !s_ready,
                    "second beat taken while busy")
    `TTW_ASSERT_IMP(a_cursor_in_range, aclk, aresetn, 1'b1,
                    (row_ext < ROWS) && (col_ext < COLUMNS), "cursor off screen")
    `TTW_ASSERT_IMP(a_no_write_when_done, aclk, aresetn, state_reg == S_DONE, !ram_we,
                    "screen written while result pending")
    `TTW_ASSERT_IMP(a_scroll_stays_above_bottom, aclk, aresetn,
                    (state_reg == S_SCROLL) && ram_we,
                    32'(ram_waddr) < (ROWS - 1) * COLUMNS, "scroll copy hit bottom row")
    `TTW_ASSERT_NXT(a_done_loads_result, aclk, aresetn,
                    (state_reg == S_DONE) && (!m_valid_reg || m_ready),
                    m_valid_reg && (state_reg == S_IDLE), "result not registered")

endmodule

// ===== tb/terminal_screen_check.sv =====
`timescale 1ns / 100ps

module terminal_screen_check
    import ttw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_item_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_item_t  m_data,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output int         mismatches,
    output int         waiting,
    output int         results_seen,
    output int         scrolls_seen,
    output int         clears_seen
);

    logic [CELL_W-1:0] screen_shadow [CELLS];
    int                row_pos;
    int                col_pos;
    logic [7:0]        text_color;
    out_item_t         expected_beats [$];

    function automatic logic [CELL_W-1:0] blank_cell();
        return {text_color, BLANK_CODE};
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) screen_shadow[i] = blank_cell();
        row_pos = 0;
        col_pos = 0;
    endfunction

    function automatic void line_feed();
        col_pos = 0;
        row_pos++;
        if (row_pos < ROWS) return;
        // scroll up one line, blank bottom row in the current color
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
        for (int i = 0; i < COLUMNS; i++) screen_shadow[(ROWS - 1) * COLUMNS + i] = blank_cell();
        row_pos = ROWS - 1;
        scrolls_seen++;
    endfunction

    function automatic out_item_t predict_beat(input in_item_t it);
        out_item_t res;
        res = '0;
        case (it.opcode)
            OP_PUT: begin
                if (it.char_code == NEWLINE_CODE) begin
                    line_feed();
                end else begin
                    screen_shadow[row_pos * COLUMNS + col_pos] = {text_color, it.char_code};
                    col_pos++;
                    if (col_pos >= COLUMNS) line_feed();
                end
            end
            OP_CLEAR: begin
                blank_screen();
                clears_seen++;
            end
            OP_READ: begin
                if (it.read_row < ROWS && it.read_column < COLUMNS)
                    res.cell_value = screen_shadow[it.read_row * COLUMNS + it.read_column];
            end
            default: ;  // unused code leaves everything alone
        endcase
        res.cursor_row    = CUR_ROW_W'(row_pos);
        res.cursor_column = CUR_COL_W'(col_pos);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result beat %0d: %s got 0x%0h, wanted 0x%0h",
                 $time, results_seen, field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            text_color = TEXT_COLOR_RESET;
            blank_screen();
            expected_beats.delete();
            mismatches   = 0;
            results_seen = 0;
            scrolls_seen = 0;
            clears_seen  = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_beats.size() == 0) begin
                    report_mismatch("unrequested result", 32'(m_data), 32'd0);
                end else begin
                    want = expected_beats.pop_front();
                    if (m_data.cell_value !== want.cell_value)
                        report_mismatch("cell_value", 32'(m_data.cell_value),
                                        32'(want.cell_value));
                    if (m_data.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", 32'(m_data.cursor_row),
                                        32'(want.cursor_row));
                    if (m_data.cursor_column !== want.cursor_column)
                        report_mismatch("cursor_column", 32'(m_data.cursor_column),
                                        32'(want.cursor_column));
                end
            end
            if (s_valid && s_ready) expected_beats.push_back(predict_beat(s_data));
            if (cfg_we) text_color = cfg_wdata;
        end
        waiting = expected_beats.size();
    end

endmodule

// ===== tb/tb_text_terminal_writer.sv =====
`timescale 1ns / 100ps

module tb_text_terminal_writer;
    import ttw_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         STUCK_LIMIT = 20000;
    localparam int         PHASES      = 6;
    localparam int         PHASE_BEATS = 250;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    logic idle_on;
    logic hold_req;
    logic hold_done;
    int   mismatches;
    int   waiting;
    int   results_seen;
    int   scrolls_seen;
    int   clears_seen;
    int   stuck_cycles;
    int   colors_used;

    text_terminal_writer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    terminal_screen_check u_screen_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .results_seen (results_seen),
        .scrolls_seen (scrolls_seen),
        .clears_seen  (clears_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // nothing accepted on either side for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("no beat moved for %0d cycles", STUCK_LIMIT);
                $display("text_terminal_writer: mismatch");
                $finish;
            end
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        m_ready   = 1'b0;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t make_beat(input logic [1:0] op, input logic [7:0] ch,
                                           input int r, input int c);
        in_item_t it;
        it.opcode      = op;
        it.char_code   = ch;
        it.read_row    = CUR_ROW_W'(r);
        it.read_column = CUR_COL_W'(c);
        return it;
    endfunction

    function automatic in_item_t next_random_beat();
        in_item_t it;
        int       pick;
        it.opcode      = OP_PUT;
        it.char_code   = CHAR_W'($urandom_range(0, 255));
        it.read_row    = CUR_ROW_W'($urandom_range(0, 31));
        it.read_column = CUR_COL_W'($urandom_range(0, 127));
        pick = $urandom_range(0, 999);
        if (pick < 600) begin
            it.char_code = CHAR_W'($urandom_range(8'h20, 8'h7E));
        end else if (pick < 650) begin
            it.char_code = CHAR_W'($urandom_range(0, 255));
        end else if (pick < 730) begin
            it.char_code = NEWLINE_CODE;
        end else if (pick < 960) begin
            // lean toward the bottom rows where fresh text lands
            it.opcode      = OP_READ;
            it.read_row    = CUR_ROW_W'($urandom_range(0, 1)
                                        ? $urandom_range(ROWS - 5, ROWS - 1)
                                        : $urandom_range(0, ROWS - 1));
            it.read_column = CUR_COL_W'($urandom_range(0, COLUMNS - 1));
        end else if (pick < 985) begin
            it.opcode = OP_READ;
        end else if (pick < 997) begin
            it.opcode = OP_UNUSED;
        end else begin
            it.opcode = OP_CLEAR;
        end
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input in_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic set_color(input logic [7:0] color);
        s_valid <= 1'b0;
        wait (waiting == 0);
        repeat (5) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= color;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        colors_used++;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        idle_on     = 1'b0;
        hold_req    = 1'b0;
        colors_used = 1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        // block clears its screen after reset before taking beats
        do @(negedge aclk); while (!s_ready);

        send_beat(make_beat(OP_PUT, 8'h41, 0, 0));
        send_beat(make_beat(OP_PUT, 8'h00, 31, 127));
        send_beat(make_beat(OP_PUT, 8'hFF, 0, 0));
        send_beat(make_beat(OP_READ, 8'hFF, 0, 0));
        send_beat(make_beat(OP_READ, 8'h00, 0, 2));
        send_beat(make_beat(OP_PUT, NEWLINE_CODE, 0, 0));
        send_beat(make_beat(OP_READ, 8'h00, 0, 3));
        send_beat(make_beat(OP_UNUSED, 8'hFF, 31, 127));
        send_beat(make_beat(OP_READ, 8'h00, ROWS - 1, COLUMNS - 1));
        send_beat(make_beat(OP_READ, 8'h00, ROWS, 0));
        send_beat(make_beat(OP_READ, 8'h00, 0, COLUMNS));
        send_beat(make_beat(OP_READ, 8'hFF, 31, 127));
        send_beat(make_beat(OP_PUT, 8'h7A, 0, 0));

        // new color must not touch cells already written
        set_color(8'h3C);
        send_beat(make_beat(OP_PUT, 8'h42, 0, 0));
        send_beat(make_beat(OP_READ, 8'h00, 1, 0));
        send_beat(make_beat(OP_READ, 8'h00, 1, 1));
        send_beat(make_beat(OP_CLEAR, 8'h00, 0, 0));
        send_beat(make_beat(OP_READ, 8'h00, 12, 40));
        send_beat(make_beat(OP_READ, 8'h00, ROWS - 1, COLUMNS - 1));
        send_beat(make_beat(OP_PUT, NEWLINE_CODE, 0, 0));
        send_beat(make_beat(OP_READ, 8'h00, 0, 0));

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)      set_color(8'hFF);
            else if (p == 1) set_color(8'h00);
            else             set_color(8'($urandom_range(0, 255)));
            idle_on = (p < PHASES - 1);
            if (p == 1) hold_req = 1'b1;
            if (p % 2 == 1) send_beat(make_beat(OP_CLEAR, 8'h00, 0, 0));
            for (int i = 0; i < PHASE_BEATS; i++) begin
                if (p == 2 && i == PHASE_BEATS / 2) begin
                    // let the block drain completely mid-phase
                    s_valid <= 1'b0;
                    wait (waiting == 0);
                    @(negedge aclk);
                end
                send_beat(next_random_beat());
            end
        end
        s_valid <= 1'b0;

        wait (waiting == 0);
        repeat (20) @(posedge aclk);
        $display("covered %0d result beats, %0d scrolls and %0d clears", results_seen,
                 scrolls_seen, clears_seen);
        $display("across %0d text color settings, with stalls on both sides", colors_used);
        if (mismatches == 0 && waiting == 0) begin
            $display("text_terminal_writer: match");
        end else begin
            $display("text_terminal_writer: mismatch");
        end
        $finish;
    end

endmodule
